@@ hw/rtl/atr_pkg.sv @@
`default_nettype none

package atr_pkg;

  // Fixed field widths of the price bar and the smoothed range
  localparam int PRICE_BITS   = 32;
  localparam int FRAC_BITS    = 16;
  localparam int ATR_BITS     = PRICE_BITS + FRAC_BITS;
  localparam int ATR_HALF     = ATR_BITS / 2;

  // Averaging period register
  localparam int PERIOD_BITS  = 11;
  localparam int PERIOD_LIMIT = (2 ** PERIOD_BITS) - 1;
  localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 11'd14;

  // Command queue between front and back
  localparam int QUEUE_DEPTH  = 2;

  // Kind of bar handed to the back end
  typedef enum logic {
    OP_FIRST = 1'b0,  // no previous close, nothing to accumulate
    OP_RANGE = 1'b1   // true range present
  } atr_op_e;

  typedef struct packed {
    atr_op_e                op;
    logic [PRICE_BITS-1:0]  range;
  } atr_cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/atr_front.sv @@
`default_nettype none

module atr_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  input  wire logic                          q_full_i,
  input  wire logic [atr_pkg::PRICE_BITS-1:0] bar_high_i,
  input  wire logic [atr_pkg::PRICE_BITS-1:0] bar_low_i,
  input  wire logic [atr_pkg::PRICE_BITS-1:0] bar_close_i,
  output logic                               q_push_o,
  output atr_pkg::atr_cmd_t                  cmd_o
);
  import atr_pkg::*;

  logic [PRICE_BITS-1:0] last_close_q, last_close_d;
  logic                  have_close_q, have_close_d;
  logic                  accept;
  logic                  hl_ge;
  logic [PRICE_BITS-1:0] hl_diff;
  logic [PRICE_BITS-1:0] hc_diff;
  logic [PRICE_BITS-1:0] lc_diff;
  logic [PRICE_BITS-1:0] tr;

  assign accept   = push_i & ~q_full_i;
  assign q_push_o = accept;

  // Form the true range against the stored close
  always_comb begin
    hl_ge   = bar_high_i >= bar_low_i;
    hl_diff = bar_high_i - bar_low_i;
    hc_diff = (bar_high_i >= last_close_q) ? (bar_high_i - last_close_q)
                                           : (last_close_q - bar_high_i);
    lc_diff = (bar_low_i >= last_close_q) ? (bar_low_i - last_close_q)
                                          : (last_close_q - bar_low_i);
    tr      = (hc_diff >= lc_diff) ? hc_diff : lc_diff;
    // high below low counts as negative and never wins
    if (hl_ge && (hl_diff > tr)) begin
      tr = hl_diff;
    end
  end

  // Classify the beat for the back end
  always_comb begin
    cmd_o.op    = have_close_q ? OP_RANGE : OP_FIRST;
    cmd_o.range = have_close_q ? tr : '0;
  end

  // Hold the previous close
  always_comb begin
    last_close_d = last_close_q;
    have_close_d = have_close_q;
    if (accept) begin
      last_close_d = bar_close_i;
      have_close_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_close_q <= '0;
      have_close_q <= 1'b0;
    end else begin
      last_close_q <= last_close_d;
      have_close_q <= have_close_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/atr_queue.sv @@
`default_nettype none

module atr_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  atr_pkg::atr_cmd_t      wdata_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output atr_pkg::atr_cmd_t      rdata_o,
  output logic                   empty_o
);
  import atr_pkg::*;

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  atr_cmd_t              entry_q [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_BITS-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_BITS-1:0]   count_q, count_d;
  logic                  do_push;
  logic                  do_pop;

  assign full_o  = (count_q == CNT_BITS'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = entry_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/atr_back.sv @@
`default_nettype none

module atr_back #(
  parameter int PERIOD_MAX = 1024
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [atr_pkg::PERIOD_BITS-1:0] period_i,
  input  wire logic                           q_empty_i,
  input  atr_pkg::atr_cmd_t                   q_data_i,
  output logic                                q_pop_o,
  output logic                                empty_o,
  input  wire logic                           pop_i,
  output logic [atr_pkg::ATR_BITS-1:0]        avg_range_o,
  output logic                                atr_valid_o,
  output logic [atr_pkg::PRICE_BITS-1:0]      range_of_bar_o
);
  import atr_pkg::*;

  localparam int NMAX      = (PERIOD_MAX < PERIOD_LIMIT) ? PERIOD_MAX : PERIOD_LIMIT;
  localparam int N_BITS    = $clog2(NMAX + 1);
  localparam int SUM_BITS  = PRICE_BITS + N_BITS;
  localparam int DIV_BITS  = ATR_BITS + N_BITS + 1;
  localparam int CNT_BITS  = $clog2(DIV_BITS);
  localparam int PROD_BITS = N_BITS + ATR_HALF;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_MUL_LO = 5'b00010,
    ST_MUL_HI = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_WRITE  = 5'b10000
  } back_state_e;

  back_state_e             state_q, state_d;
  logic [N_BITS-1:0]       seen_q, seen_d;
  logic [SUM_BITS-1:0]     sum_q, sum_d;
  logic [ATR_BITS-1:0]     atr_q, atr_d;
  logic                    ready_q, ready_d;
  logic [PRICE_BITS-1:0]   range_q, range_d;
  logic [DIV_BITS-1:0]     dq_q, dq_d;
  logic [N_BITS-1:0]       rem_q, rem_d;
  logic [CNT_BITS-1:0]     cnt_q, cnt_d;
  logic                    out_valid_q, out_valid_d;
  logic [ATR_BITS-1:0]     out_atr_q, out_atr_d;
  logic                    out_ready_q, out_ready_d;
  logic [PRICE_BITS-1:0]   out_range_q, out_range_d;

  logic [N_BITS-1:0]       n_eff;
  logic [N_BITS-1:0]       n_m1;
  logic [SUM_BITS-1:0]     sum_next;
  logic [N_BITS-1:0]       seen_next;
  logic [ATR_HALF-1:0]     mul_a;
  logic [PROD_BITS-1:0]    prod;
  logic [N_BITS:0]         trial;
  logic [N_BITS:0]         trial_sub;
  logic                    take_bit;
  logic [N_BITS-1:0]       rem_next;
  logic                    out_free;

  // Clamp the period into 1..NMAX
  always_comb begin
    if (period_i == '0) begin
      n_eff = N_BITS'(1);
    end else if (period_i > PERIOD_BITS'(NMAX)) begin
      n_eff = N_BITS'(NMAX);
    end else begin
      n_eff = N_BITS'(period_i);
    end
  end

  assign n_m1      = n_eff - 1'b1;
  assign sum_next  = sum_q + SUM_BITS'(q_data_i.range);
  assign seen_next = seen_q + 1'b1;

  // Shared multiplier: one half of the ATR per cycle
  assign mul_a = (state_q == ST_MUL_HI) ? atr_q[ATR_BITS-1:ATR_HALF] : atr_q[ATR_HALF-1:0];
  assign prod  = {{ATR_HALF{1'b0}}, n_m1} * {{N_BITS{1'b0}}, mul_a};

  // Restoring divider step, one quotient bit per cycle
  assign trial     = {rem_q, dq_q[DIV_BITS-1]};
  assign take_bit  = trial >= {1'b0, n_eff};
  assign trial_sub = trial - {1'b0, n_eff};
  assign rem_next  = take_bit ? trial_sub[N_BITS-1:0] : trial[N_BITS-1:0];

  assign out_free = ~out_valid_q | pop_i;
  assign q_pop_o  = (state_q == ST_IDLE) & ~q_empty_i;

  // Sequence warm-up, smoothing and result handoff
  always_comb begin
    state_d     = state_q;
    seen_d      = seen_q;
    sum_d       = sum_q;
    atr_d       = atr_q;
    ready_d     = ready_q;
    range_d     = range_q;
    dq_d        = dq_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_atr_d   = out_atr_q;
    out_ready_d = out_ready_q;
    out_range_d = out_range_q;

    // drop the result once taken
    if (pop_i && out_valid_q) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          range_d = q_data_i.range;
          if (q_data_i.op == OP_FIRST) begin
            state_d = ST_WRITE;
          end else if (ready_q) begin
            state_d = ST_MUL_LO;
          end else begin
            sum_d  = sum_next;
            seen_d = seen_next;
            if (seen_next >= n_eff) begin
              dq_d    = DIV_BITS'({sum_next, {FRAC_BITS{1'b0}}});
              rem_d   = '0;
              cnt_d   = CNT_BITS'(DIV_BITS - 1);
              state_d = ST_DIV;
            end else begin
              state_d = ST_WRITE;
            end
          end
        end
      end
      ST_MUL_LO: begin
        dq_d    = DIV_BITS'(prod) + DIV_BITS'({range_q, {FRAC_BITS{1'b0}}});
        state_d = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        dq_d    = dq_q + (DIV_BITS'(prod) << ATR_HALF);
        rem_d   = '0;
        cnt_d   = CNT_BITS'(DIV_BITS - 1);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        dq_d  = {dq_q[DIV_BITS-2:0], take_bit};
        rem_d = rem_next;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          atr_d   = {dq_q[ATR_BITS-2:0], take_bit};
          ready_d = 1'b1;
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_atr_d   = ready_q ? atr_q : '0;
          out_ready_d = ready_q;
          out_range_d = range_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seen_q      <= '0;
      sum_q       <= '0;
      atr_q       <= '0;
      ready_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seen_q      <= seen_d;
      sum_q       <= sum_d;
      atr_q       <= atr_d;
      ready_q     <= ready_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    range_q     <= range_d;
    dq_q        <= dq_d;
    rem_q       <= rem_d;
    cnt_q       <= cnt_d;
    out_atr_q   <= out_atr_d;
    out_ready_q <= out_ready_d;
    out_range_q <= out_range_d;
  end

  assign empty_o        = ~out_valid_q;
  assign avg_range_o    = out_atr_q;
  assign atr_valid_o    = out_ready_q;
  assign range_of_bar_o = out_range_q;

endmodule

`default_nettype wire

@@ hw/rtl/average_true_range_unit.sv @@
// Channel   Direction  Handshake            Beat
// bars      in         push / full          bar_high_i, bar_low_i, bar_close_i
// results   out        empty / pop          avg_range_o, atr_valid_o, range_of_bar_o
// config    in         cfg_we_i (no wait)   cfg_wdata_i -> averaging period
//
// A smoothing bar passes the back end as queue pop, two multiply passes, one quotient
// bit a cycle, output load. The bar that forms the first average skips the multiply
// passes; warm-up bars that only accumulate and the first bar after reset go from
// the queue pop straight to the output load. A bar is registered in the queue before
// the back end sees it; a result waiting for pop holds the back end in its write step,
// while the two-entry queue keeps taking bars until it fills.
// Reset clears all running state at once; no clearing pass is needed.
`default_nettype none

module average_true_range_unit #(
  parameter int PERIOD_MAX = 1024
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic [atr_pkg::PRICE_BITS-1:0]  bar_high_i,
  input  wire logic [atr_pkg::PRICE_BITS-1:0]  bar_low_i,
  input  wire logic [atr_pkg::PRICE_BITS-1:0]  bar_close_i,
  output logic                                empty,
  input  wire logic                           pop,
  output logic [atr_pkg::ATR_BITS-1:0]        avg_range_o,
  output logic                                atr_valid_o,
  output logic [atr_pkg::PRICE_BITS-1:0]      range_of_bar_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [atr_pkg::PERIOD_BITS-1:0] cfg_wdata_i
);
  import atr_pkg::*;

  logic [PERIOD_BITS-1:0] period_q, period_d;
  logic                   q_push;
  logic                   q_full;
  logic                   q_pop;
  logic                   q_empty;
  atr_cmd_t               q_wdata;
  atr_cmd_t               q_rdata;

  // Hold the averaging period
  always_comb begin
    period_d = period_q;
    if (cfg_we_i) begin
      period_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RESET;
    end else begin
      period_q <= period_d;
    end
  end

  assign full = q_full;

  atr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .q_full_i    (q_full),
    .bar_high_i  (bar_high_i),
    .bar_low_i   (bar_low_i),
    .bar_close_i (bar_close_i),
    .q_push_o    (q_push),
    .cmd_o       (q_wdata)
  );

  atr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  atr_back #(
    .PERIOD_MAX (PERIOD_MAX)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .period_i       (period_q),
    .q_empty_i      (q_empty),
    .q_data_i       (q_rdata),
    .q_pop_o        (q_pop),
    .empty_o        (empty),
    .pop_i          (pop),
    .avg_range_o    (avg_range_o),
    .atr_valid_o    (atr_valid_o),
    .range_of_bar_o (range_of_bar_o)
  );

endmodule

`default_nettype wire

@@ hw/rtl/atr_checker.sv @@
`default_nettype none

module atr_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           push,
  input  wire logic                           full,
  input  wire logic                           empty,
  input  wire logic                           pop,
  input  wire logic [atr_pkg::ATR_BITS-1:0]    avg_range_o,
  input  wire logic                           atr_valid_o,
  input  wire logic [atr_pkg::PRICE_BITS-1:0]  range_of_bar_o
);

  logic valid_seen_q, valid_seen_d;

  // Remember that a valid average has left the block
  always_comb begin
    valid_seen_d = valid_seen_q;
    if (pop && !empty && atr_valid_o) begin
      valid_seen_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_seen_q <= 1'b0;
    end else begin
      valid_seen_q <= valid_seen_d;
    end
  end

  // A waiting result holds until taken
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(avg_range_o) && $stable(atr_valid_o)
                          && $stable(range_of_bar_o)))
    else $error("result changed while waiting");

  // No average shown before warm-up completes
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !atr_valid_o) |-> (avg_range_o == '0))
    else $error("nonzero average marked invalid");

  // Once valid, the average stays valid until reset
  a_valid_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && valid_seen_q) |-> atr_valid_o)
    else $error("average fell back to invalid");

  // Handshake lines always carry known levels out of reset
  a_flags_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({push, full, empty, pop}))
    else $error("handshake line unknown");

endmodule

bind average_true_range_unit atr_checker u_atr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .push           (push),
  .full           (full),
  .empty          (empty),
  .pop            (pop),
  .avg_range_o    (avg_range_o),
  .atr_valid_o    (atr_valid_o),
  .range_of_bar_o (range_of_bar_o)
);

`default_nettype wire
